FILE: sv/cpu65_pkg.sv
package cpu65_pkg;

    typedef enum logic [5:0] {
        F_ADC = 6'd0,  F_AND = 6'd1,  F_ASL = 6'd2,  F_BCC = 6'd3,
        F_BCS = 6'd4,  F_BEQ = 6'd5,  F_BIT = 6'd6,  F_BMI = 6'd7,
        F_BNE = 6'd8,  F_BPL = 6'd9,  F_BRK = 6'd10, F_BVC = 6'd11,
        F_BVS = 6'd12, F_CLC = 6'd13, F_CLD = 6'd14, F_CLI = 6'd15,
        F_CLV = 6'd16, F_CMP = 6'd17, F_CPX = 6'd18, F_CPY = 6'd19,
        F_DEC = 6'd20, F_DEX = 6'd21, F_DEY = 6'd22, F_EOR = 6'd23,
        F_INC = 6'd24, F_INX = 6'd25, F_INY = 6'd26, F_JMP = 6'd27,
        F_JSR = 6'd28, F_LDA = 6'd29, F_LDX = 6'd30, F_LDY = 6'd31,
        F_LSR = 6'd32, F_NOP = 6'd33, F_ORA = 6'd34, F_PHA = 6'd35,
        F_PHP = 6'd36, F_PLA = 6'd37, F_PLP = 6'd38, F_ROL = 6'd39,
        F_ROR = 6'd40, F_RTI = 6'd41, F_RTS = 6'd42, F_SBC = 6'd43,
        F_SEC = 6'd44, F_SED = 6'd45, F_SEI = 6'd46, F_STA = 6'd47,
        F_STX = 6'd48, F_STY = 6'd49, F_TAX = 6'd50, F_TAY = 6'd51,
        F_TSX = 6'd52, F_TXA = 6'd53, F_TXS = 6'd54, F_TYA = 6'd55,
        F_XXX = 6'd56
    } t_func;

    localparam logic [7:0] FL_C = 8'h01;
    localparam logic [7:0] FL_Z = 8'h02;
    localparam logic [7:0] FL_I = 8'h04;
    localparam logic [7:0] FL_D = 8'h08;
    localparam logic [7:0] FL_B = 8'h10;
    localparam logic [7:0] FL_U = 8'h20;
    localparam logic [7:0] FL_V = 8'h40;
    localparam logic [7:0] FL_N = 8'h80;

    typedef struct packed {
        logic [5:0]        func;
        logic [7:0]        operand;
        logic [15:0]       eff_address;
        logic signed [7:0] branch_offset;
        logic [15:0]       pc_in;
        logic              acc_mode;
    } t_in_word;

    typedef struct packed {
        logic [15:0] pc_out;
        logic        mem_write;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  status_out;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  sp_out;
        logic [1:0]  extra_cycles;
        logic        may_add_cycle;
        logic        illegal;
    } t_out_word;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } t_regs;

    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] data;
    } t_push;

endpackage

FILE: sv/cpu6502_execute_unit.sv
// Execute stage of a 6502 core, binary arithmetic only. One decoded word
// enters per cycle when the input register is empty or its word commits,
// which needs the result register free or being drained; the word is taken
// into the input register and its result is registered when the word commits,
// so the sustained rate is one word per cycle while the output is not stalled.
// The stack page lives in four byte-interleaved banks so that up to three
// pushes or pulls complete in the same cycle; pull data is read ahead into a
// register from the stack pointer the executing word leaves behind, with
// bypass of same-cycle writes. break_vector is written through i_cfg_we/i_cfg_data.
module cpu6502_execute_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cpu65_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cpu65_pkg::t_out_word o_out_word
);

    logic                 r_in_valid, r_out_valid;
    cpu65_pkg::t_in_word  r_in;
    cpu65_pkg::t_out_word r_out;
    cpu65_pkg::t_regs     r_regs, n_regs;
    logic [15:0]          r_bv;
    cpu65_pkg::t_push     push;
    cpu65_pkg::t_out_word n_out;
    logic [2:0][7:0]      pull;
    logic                 commit;

    assign commit      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || commit;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    cpu65_exec u_exec (
        .i_word         (r_in),
        .i_regs         (r_regs),
        .i_break_vector (r_bv),
        .i_pull         (pull),
        .o_regs         (n_regs),
        .o_push         (push),
        .o_word         (n_out)
    );

    cpu65_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
        .i_clk     (i_clk),
        .i_we      (commit),
        .i_wr_base (r_regs.sp),
        .i_push    (push),
        .i_rd_base (commit ? n_regs.sp : r_regs.sp),
        .o_pull    (pull)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '0;
            r_bv        <= 16'h0000;
        end else begin
            if (i_cfg_we) begin
                r_bv <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (commit) begin
                r_regs      <= n_regs;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: sv/cpu65_stack.sv
module cpu65_stack #(
    parameter int STACK_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [7:0]        i_wr_base,
    input  cpu65_pkg::t_push  i_push,
    input  logic [7:0]        i_rd_base,
    output logic [2:0][7:0]   o_pull
);

    localparam int IDX_W  = $clog2(STACK_DEPTH) - 2;
    localparam int BANK_D = STACK_DEPTH / 4;

    logic [7:0] mem [4][BANK_D];
    logic [7:0] r_rd [4];
    logic [7:0] r_base;

    logic             w_en  [4];
    logic [IDX_W-1:0] w_idx [4];
    logic [7:0]       w_dat [4];
    logic [IDX_W-1:0] rd_idx[4];

    always_comb begin
        logic [7:0] a;
        for (int b = 0; b < 4; b++) begin
            w_en[b]   = 1'b0;
            w_idx[b]  = '0;
            w_dat[b]  = '0;
            rd_idx[b] = '0;
            for (int k = 0; k < 3; k++) begin
                a = i_wr_base - 8'(k);
                if (i_we && (2'(k) < i_push.count) && (a[1:0] == 2'(b))) begin
                    w_en[b]  = 1'b1;
                    w_idx[b] = a[IDX_W+1:2];
                    w_dat[b] = i_push.data[k];
                end
            end
            for (int k = 1; k < 5; k++) begin
                a = i_rd_base + 8'(k);
                if (a[1:0] == 2'(b)) begin
                    rd_idx[b] = a[IDX_W+1:2];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (w_en[b]) begin
                mem[b][w_idx[b]] <= w_dat[b];
            end
            if (w_en[b] && (w_idx[b] == rd_idx[b])) begin
                r_rd[b] <= w_dat[b];
            end else begin
                r_rd[b] <= mem[b][rd_idx[b]];
            end
        end
        r_base <= i_rd_base;
    end

    always_comb begin
        logic [7:0] a;
        for (int k = 0; k < 3; k++) begin
            a = r_base + 8'(k + 1);
            o_pull[k] = r_rd[a[1:0]];
        end
    end

endmodule

FILE: sv/cpu65_exec.sv
module cpu65_exec (
    input  cpu65_pkg::t_in_word  i_word,
    input  cpu65_pkg::t_regs     i_regs,
    input  logic [15:0]          i_break_vector,
    input  logic [2:0][7:0]      i_pull,
    output cpu65_pkg::t_regs     o_regs,
    output cpu65_pkg::t_push     o_push,
    output cpu65_pkg::t_out_word o_word
);

    logic [7:0]  m, r, mm, cmp_reg, p;
    logic [8:0]  sum, diff;
    logic [15:0] pc, npc, ret, bra;
    logic        wr, may, ill, take, is_br, is_sh, is_add, is_cmp, zn_r;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    cpu65_pkg::t_regs s;

    assign pc  = i_word.pc_in;
    assign m   = i_word.acc_mode ? i_regs.a : i_word.operand;
    assign p   = i_regs.p;
    assign bra = pc + {{8{i_word.branch_offset[7]}}, i_word.branch_offset};

    always_comb begin
        s       = i_regs;
        npc     = pc;
        wr      = 1'b0;
        may     = 1'b0;
        ill     = 1'b0;
        take    = 1'b0;
        is_br   = 1'b0;
        is_sh   = 1'b0;
        is_add  = 1'b0;
        is_cmp  = 1'b0;
        zn_r    = 1'b0;
        waddr   = 16'h0000;
        wdata   = 8'h00;
        r       = 8'h00;
        mm      = m;
        cmp_reg = i_regs.a;
        ret     = pc + 16'd1;
        o_push  = '0;
        unique case (cpu65_pkg::t_func'(i_word.func))
            cpu65_pkg::F_ADC: begin is_add = 1'b1; may = 1'b1; end
            cpu65_pkg::F_SBC: begin is_add = 1'b1; may = 1'b1; mm = ~m; end
            cpu65_pkg::F_AND: begin s.a = i_regs.a & m; may = 1'b1; end
            cpu65_pkg::F_EOR: begin s.a = i_regs.a ^ m; may = 1'b1; end
            cpu65_pkg::F_ORA: begin s.a = i_regs.a | m; may = 1'b1; end
            cpu65_pkg::F_ASL: begin
                s.p[0] = m[7]; r = {m[6:0], 1'b0}; is_sh = 1'b1;
            end
            cpu65_pkg::F_LSR: begin
                s.p[0] = m[0]; r = {1'b0, m[7:1]}; is_sh = 1'b1;
            end
            cpu65_pkg::F_ROL: begin
                s.p[0] = m[7]; r = {m[6:0], p[0]}; is_sh = 1'b1;
            end
            cpu65_pkg::F_ROR: begin
                s.p[0] = m[0]; r = {p[0], m[7:1]}; is_sh = 1'b1;
            end
            cpu65_pkg::F_BCC: begin is_br = 1'b1; take = ~p[0]; end
            cpu65_pkg::F_BCS: begin is_br = 1'b1; take = p[0]; end
            cpu65_pkg::F_BEQ: begin is_br = 1'b1; take = p[1]; end
            cpu65_pkg::F_BNE: begin is_br = 1'b1; take = ~p[1]; end
            cpu65_pkg::F_BMI: begin is_br = 1'b1; take = p[7]; end
            cpu65_pkg::F_BPL: begin is_br = 1'b1; take = ~p[7]; end
            cpu65_pkg::F_BVC: begin is_br = 1'b1; take = ~p[6]; end
            cpu65_pkg::F_BVS: begin is_br = 1'b1; take = p[6]; end
            cpu65_pkg::F_BIT: begin
                s.p[6] = m[6]; s.p[7] = m[7]; s.p[1] = ((i_regs.a & m) == 8'h00);
            end
            cpu65_pkg::F_BRK: begin
                o_push.count   = 2'd3;
                o_push.data[0] = ret[15:8];
                o_push.data[1] = ret[7:0];
                o_push.data[2] = p | cpu65_pkg::FL_B | cpu65_pkg::FL_U;
                s.sp = i_regs.sp - 8'd3;
                s.p  = (p | cpu65_pkg::FL_I) & ~cpu65_pkg::FL_B;
                npc  = i_break_vector;
            end
            cpu65_pkg::F_CLC: s.p = p & ~cpu65_pkg::FL_C;
            cpu65_pkg::F_CLD: s.p = p & ~cpu65_pkg::FL_D;
            cpu65_pkg::F_CLI: s.p = p & ~cpu65_pkg::FL_I;
            cpu65_pkg::F_CLV: s.p = p & ~cpu65_pkg::FL_V;
            cpu65_pkg::F_SEC: s.p = p | cpu65_pkg::FL_C;
            cpu65_pkg::F_SED: s.p = p | cpu65_pkg::FL_D;
            cpu65_pkg::F_SEI: s.p = p | cpu65_pkg::FL_I;
            cpu65_pkg::F_CMP: begin is_cmp = 1'b1; may = 1'b1; end
            cpu65_pkg::F_CPX: begin is_cmp = 1'b1; cmp_reg = i_regs.x; end
            cpu65_pkg::F_CPY: begin is_cmp = 1'b1; cmp_reg = i_regs.y; end
            cpu65_pkg::F_DEC: begin
                r = m - 8'd1; zn_r = 1'b1; wr = 1'b1; waddr = i_word.eff_address; wdata = r;
            end
            cpu65_pkg::F_INC: begin
                r = m + 8'd1; zn_r = 1'b1; wr = 1'b1; waddr = i_word.eff_address; wdata = r;
            end
            cpu65_pkg::F_DEX: s.x = i_regs.x - 8'd1;
            cpu65_pkg::F_DEY: s.y = i_regs.y - 8'd1;
            cpu65_pkg::F_INX: s.x = i_regs.x + 8'd1;
            cpu65_pkg::F_INY: s.y = i_regs.y + 8'd1;
            cpu65_pkg::F_JMP: npc = i_word.eff_address;
            cpu65_pkg::F_JSR: begin
                ret            = pc - 16'd1;
                o_push.count   = 2'd2;
                o_push.data[0] = ret[15:8];
                o_push.data[1] = ret[7:0];
                s.sp = i_regs.sp - 8'd2;
                npc  = i_word.eff_address;
            end
            cpu65_pkg::F_LDA: begin s.a = m; may = 1'b1; end
            cpu65_pkg::F_LDX: begin s.x = m; may = 1'b1; end
            cpu65_pkg::F_LDY: begin s.y = m; may = 1'b1; end
            cpu65_pkg::F_NOP: ;
            cpu65_pkg::F_PHA: begin
                o_push.count = 2'd1; o_push.data[0] = i_regs.a; s.sp = i_regs.sp - 8'd1;
            end
            cpu65_pkg::F_PHP: begin
                o_push.count   = 2'd1;
                o_push.data[0] = p | cpu65_pkg::FL_B | cpu65_pkg::FL_U;
                s.sp = i_regs.sp - 8'd1;
                s.p  = p & ~(cpu65_pkg::FL_B | cpu65_pkg::FL_U);
            end
            cpu65_pkg::F_PLA: begin s.a = i_pull[0]; s.sp = i_regs.sp + 8'd1; end
            cpu65_pkg::F_PLP: begin
                s.p = i_pull[0] | cpu65_pkg::FL_B; s.sp = i_regs.sp + 8'd1;
            end
            cpu65_pkg::F_RTI: begin
                s.p  = i_pull[0] & ~(cpu65_pkg::FL_B | cpu65_pkg::FL_U);
                npc  = {i_pull[2], i_pull[1]};
                s.sp = i_regs.sp + 8'd3;
            end
            cpu65_pkg::F_RTS: begin
                npc  = {i_pull[1], i_pull[0]} + 16'd1;
                s.sp = i_regs.sp + 8'd2;
            end
            cpu65_pkg::F_STA: begin wr = 1'b1; waddr = i_word.eff_address; wdata = i_regs.a; end
            cpu65_pkg::F_STX: begin wr = 1'b1; waddr = i_word.eff_address; wdata = i_regs.x; end
            cpu65_pkg::F_STY: begin wr = 1'b1; waddr = i_word.eff_address; wdata = i_regs.y; end
            cpu65_pkg::F_TAX: s.x = i_regs.a;
            cpu65_pkg::F_TAY: s.y = i_regs.a;
            cpu65_pkg::F_TSX: s.x = i_regs.sp;
            cpu65_pkg::F_TXA: s.a = i_regs.x;
            cpu65_pkg::F_TXS: s.sp = i_regs.x;
            cpu65_pkg::F_TYA: s.a = i_regs.y;
            default: ill = 1'b1;
        endcase

        sum  = {1'b0, i_regs.a} + {1'b0, mm} + {8'h00, p[0]};
        diff = {1'b0, cmp_reg} - {1'b0, m};

        if (is_add) begin
            s.a    = sum[7:0];
            s.p[0] = sum[8];
            s.p[6] = ~(i_regs.a[7] ^ mm[7]) & (i_regs.a[7] ^ sum[7]);
        end

        if (is_cmp) begin
            s.p[0] = ~diff[8];
            s.p[1] = (diff[7:0] == 8'h00);
            s.p[7] = diff[7];
        end
        if (is_sh || zn_r) begin
            s.p[1] = (r == 8'h00);
            s.p[7] = r[7];
        end
        if (is_sh) begin
            if (i_word.acc_mode) begin
                s.a = r;
            end else begin
                wr = 1'b1; waddr = i_word.eff_address; wdata = r;
            end
        end
        unique case (cpu65_pkg::t_func'(i_word.func))
            cpu65_pkg::F_ADC, cpu65_pkg::F_SBC, cpu65_pkg::F_AND, cpu65_pkg::F_EOR,
            cpu65_pkg::F_ORA, cpu65_pkg::F_LDA, cpu65_pkg::F_PLA, cpu65_pkg::F_TXA,
            cpu65_pkg::F_TYA: begin
                s.p[1] = (s.a == 8'h00); s.p[7] = s.a[7];
            end
            cpu65_pkg::F_DEX, cpu65_pkg::F_INX, cpu65_pkg::F_LDX, cpu65_pkg::F_TAX,
            cpu65_pkg::F_TSX: begin
                s.p[1] = (s.x == 8'h00); s.p[7] = s.x[7];
            end
            cpu65_pkg::F_DEY, cpu65_pkg::F_INY, cpu65_pkg::F_LDY, cpu65_pkg::F_TAY: begin
                s.p[1] = (s.y == 8'h00); s.p[7] = s.y[7];
            end
            default: ;
        endcase

        o_word = '0;
        if (is_br && take) begin
            npc = bra;
            o_word.extra_cycles = (bra[15:8] != pc[15:8]) ? 2'd2 : 2'd1;
        end
        o_word.pc_out        = npc;
        o_word.mem_write     = wr;
        o_word.mem_addr      = wr ? waddr : 16'h0000;
        o_word.mem_data      = wr ? wdata : 8'h00;
        o_word.status_out    = s.p;
        o_word.acc_out       = s.a;
        o_word.x_out         = s.x;
        o_word.y_out         = s.y;
        o_word.sp_out        = s.sp;
        o_word.may_add_cycle = may;
        o_word.illegal       = ill;
        o_regs               = s;
    end

endmodule
